### src/rme_pkg.sv
// Package for the rotation-matrix-to-Euler block: widths, CORDIC angle table
// and the top level's item structs; used by top level, rme_sqrt, rme_cordic.
// No dependencies.
`default_nettype none
package rme_pkg;

  localparam int ENTRY_WIDTH   = 16;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 14;

  // CORDIC sizing
  localparam int TAB_LEN  = 30;
  localparam int N_ITER   = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int GUARD    = 16;
  localparam int CIW      = ENTRY_WIDTH + 1;      // operand after one negation
  localparam int WW       = CIW + GUARD + 3;      // x/y working width
  localparam int ZW       = 35;                   // Q.30 angle accumulator
  localparam int ZFRAC    = 30;
  localparam int CLAT     = N_ITER + 2;           // CORDIC register stages
  localparam longint PI_Q30 = 64'd3373259426;
  localparam int ASH      = ZFRAC - (ANGLE_WIDTH - 3);
  localparam longint AHALF = 64'd1 << (ASH - 1);
  localparam longint PI_ANG = (PI_Q30 + AHALF) >> ASH;

  localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd7,         30'd3,         30'd1
  };

  // Square root sizing: radicand 0 .. 2^(2*(EW-2))
  localparam int CW       = ENTRY_WIDTH - 1;      // cosine width, unsigned
  localparam int SQ_VW    = 2 * (ENTRY_WIDTH - 2) + 1;
  localparam int SQ_RW    = SQ_VW + 1;
  localparam int SQ_STEPS = (SQ_VW + 1) / 2;

  localparam int CFG_W    = 15;

  typedef struct packed {
    logic signed [ENTRY_WIDTH-1:0] c0r0;
    logic signed [ENTRY_WIDTH-1:0] c0r1;
    logic signed [ENTRY_WIDTH-1:0] c1r0;
    logic signed [ENTRY_WIDTH-1:0] c1r1;
    logic signed [ENTRY_WIDTH-1:0] c2r0;
    logic signed [ENTRY_WIDTH-1:0] c2r2;
    logic signed [ENTRY_WIDTH-1:0] s;
  } entries_t;

  typedef struct packed {
    logic                          pole;
    logic signed [ANGLE_WIDTH-1:0] roll;
    logic signed [ANGLE_WIDTH-1:0] yaw;
    logic signed [ANGLE_WIDTH-1:0] pitch;
  } result_t;

endpackage
`default_nettype wire

### src/rme_sqrt.sv
// Pipelined integer square root, one restoring digit step per stage.
// Depends on rme_pkg.
`default_nettype none
module rme_sqrt (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [rme_pkg::SQ_VW-1:0] radicand,
  output logic      [rme_pkg::CW-1:0]    root
);
  import rme_pkg::*;

  logic [SQ_RW-1:0] rem [SQ_STEPS+1];
  logic [SQ_RW-1:0] res [SQ_STEPS+1];

  assign rem[0] = SQ_RW'(radicand);
  assign res[0] = '0;

  // one digit per stage, bit weight falls by a factor of four
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_RW-1:0] BITK = SQ_RW'(1) << (SQ_VW - 1 - 2 * k);
    logic [SQ_RW-1:0] trial;
    assign trial = res[k] + BITK;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BITK;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign root = res[SQ_STEPS][CW-1:0];

endmodule
`default_nettype wire

### src/rme_cordic.sv
// Unrolled vectoring CORDIC atan2 with quadrant pre-rotation, rounding and
// saturation to +/- pi. Depends on rme_pkg.
`default_nettype none
module rme_cordic (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [rme_pkg::CIW-1:0]      y_in,
  input  wire logic signed [rme_pkg::CIW-1:0]      x_in,
  output logic      signed [rme_pkg::ANGLE_WIDTH-1:0] angle
);
  import rme_pkg::*;

  localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(AHALF);
  localparam logic signed [ZW-1:0] PA_Z   = ZW'(PI_ANG);

  logic signed [WW-1:0] xs [N_ITER+1];
  logic signed [WW-1:0] ys [N_ITER+1];
  logic signed [ZW-1:0] zs [N_ITER+1];

  // fold left half-plane onto the right, scale by the guard factor
  logic signed [CIW-1:0] xn, yn;
  logic signed [ZW-1:0]  z0;
  always_comb begin
    if (x_in < 0) begin
      xn = -x_in;
      yn = -y_in;
      z0 = (y_in >= 0) ? PI_Z : -PI_Z;
    end else begin
      xn = x_in;
      yn = y_in;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= {{(WW-CIW-GUARD){xn[CIW-1]}}, xn, {GUARD{1'b0}}};
      ys[0] <= {{(WW-CIW-GUARD){yn[CIW-1]}}, yn, {GUARD{1'b0}}};
      zs[0] <= z0;
    end
  end

  // micro-rotations, hold when y is already zero
  for (genvar i = 0; i < N_ITER; i++) begin : g_iter
    localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TAB[i]);
    logic signed [WW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + AT;
        end else if (ys[i] < 0) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - AT;
        end else begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end
      end
    end
  end

  // round half up to the angle format and saturate
  logic signed [ZW-1:0] zr, r, rc;
  always_comb begin
    zr = zs[N_ITER] + HALF_Z;
    r  = zr >>> ASH;
    if (r > PA_Z) begin
      rc = PA_Z;
    end else if (r < -PA_Z) begin
      rc = -PA_Z;
    end else begin
      rc = r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= rc[ANGLE_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

### src/rotation_matrix_to_euler.sv
// Rotation matrix to Euler angles: top level with input stage, square root,
// three CORDIC units and output skid buffer. Depends on rme_pkg, rme_sqrt,
// rme_cordic.
//
// Usage:
//   s_axis carries one matrix per item, seven signed Q2.14 entries.
//   m_axis carries pitch, yaw, roll (signed Q3.13 radians) and at_pole.
//   cfg_wen/cfg_wdata write pole_threshold (Q1.14 cosine); write while idle.
// Timing:
//   One item enters per cycle while s_axis_tready is high. The pipeline runs
//   through two input stages (clamp, square), one square-root digit per stage,
//   one CORDIC micro-rotation per stage plus folding and rounding stages, and
//   the output register.
// Reset:
//   rst clears all valid bits and sets pole_threshold to 2.
// Stall:
//   The pipeline holds as a whole while the skid register is full; one item
//   still completes into the skid while the output waits, and s_axis_tready
//   drops once the skid holds it. Nothing is lost or repeated.
`default_nettype none
module rotation_matrix_to_euler (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // c0r0, c0r1, c1r0, c1r1, c2r0, c2r1, c2r2, 16 bits each from bit 0 up
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pitch, yaw, roll, 16 bits each from bit 0 up
  output logic [47:0]       m_axis_tdata,
  // at_pole
  output logic              m_axis_tuser,
  input  wire logic         cfg_wen,
  input  wire logic [14:0]  cfg_wdata
);
  import rme_pkg::*;

  localparam int EW = ENTRY_WIDTH;
  localparam logic signed [EW:0] ONE = (EW+1)'(1) << (EW - 2);
  localparam logic [SQ_VW-1:0] ONE_SQ = SQ_VW'(1) << (2 * (EW - 2));

  logic [CFG_W-1:0] pole_threshold;
  logic             en;
  logic             skid_v, out_v;
  result_t          skid, out_r, res_new;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pole_threshold <= CFG_W'(2);
    end else if (cfg_wen) begin
      pole_threshold <= cfg_wdata;
    end
  end

  assign en            = !skid_v;
  assign s_axis_tready = en;

  // stage 0: unpack, negate and clamp the arcsine argument
  logic signed [EW-1:0] in_c2r1;
  logic signed [EW:0]   sn, sc;
  entries_t             ent0;
  logic                 v0;
  assign in_c2r1 = s_axis_tdata[6*EW-1:5*EW];
  always_comb begin
    sn = -{in_c2r1[EW-1], in_c2r1};
    if (sn > ONE) begin
      sc = ONE;
    end else if (sn < -ONE) begin
      sc = -ONE;
    end else begin
      sc = sn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent0.c0r0 <= s_axis_tdata[EW-1:0];
      ent0.c0r1 <= s_axis_tdata[2*EW-1:EW];
      ent0.c1r0 <= s_axis_tdata[3*EW-1:2*EW];
      ent0.c1r1 <= s_axis_tdata[4*EW-1:3*EW];
      ent0.c2r0 <= s_axis_tdata[5*EW-1:4*EW];
      ent0.c2r2 <= s_axis_tdata[7*EW-1:6*EW];
      ent0.s    <= sc[EW-1:0];
    end
  end

  // stage 1: radicand 1 - s^2
  logic signed [2*EW-1:0] sq;
  logic [SQ_VW-1:0]       rad;
  entries_t               ent1;
  logic                   v1;
  assign sq = ent0.s * ent0.s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= ONE_SQ - sq[SQ_VW-1:0];
      ent1 <= ent0;
    end
  end

  // square root stages, entries ride alongside
  logic [CW-1:0] cosv;
  entries_t      ent_d [SQ_STEPS];
  logic          vsq   [SQ_STEPS];

  rme_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad),
    .root     (cosv)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ent_d[0] <= ent1;
      for (int k = 1; k < SQ_STEPS; k++) begin
        ent_d[k] <= ent_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        vsq[k] <= 1'b0;
      end
    end else if (en) begin
      vsq[0] <= v1;
      for (int k = 1; k < SQ_STEPS; k++) begin
        vsq[k] <= vsq[k-1];
      end
    end
  end

  // pole decision and CORDIC operand selection
  entries_t              es;
  logic                  pole_now;
  logic signed [CIW-1:0] py, px, yy, yx, ry, rx;
  assign es       = ent_d[SQ_STEPS-1];
  assign pole_now = !(cosv > pole_threshold);

  always_comb begin
    py = CIW'(es.s);
    px = CIW'({1'b0, cosv});
    yy = CIW'(es.c2r0);
    yx = CIW'(es.c2r2);
    if (pole_now) begin
      ry = -CIW'(es.c1r0);
      rx = CIW'(es.c0r0);
    end else begin
      ry = CIW'(es.c0r1);
      rx = CIW'(es.c1r1);
    end
  end

  logic signed [ANGLE_WIDTH-1:0] pitch_a, yaw_a, roll_a;

  rme_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (py),
    .x_in  (px),
    .angle (pitch_a)
  );

  rme_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (yy),
    .x_in  (yx),
    .angle (yaw_a)
  );

  rme_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (ry),
    .x_in  (rx),
    .angle (roll_a)
  );

  // valid and pole flag follow the CORDIC depth
  logic vc     [CLAT];
  logic pole_d [CLAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CLAT; k++) begin
        vc[k] <= 1'b0;
      end
    end else if (en) begin
      vc[0] <= vsq[SQ_STEPS-1];
      for (int k = 1; k < CLAT; k++) begin
        vc[k] <= vc[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pole_d[0] <= pole_now;
      for (int k = 1; k < CLAT; k++) begin
        pole_d[k] <= pole_d[k-1];
      end
    end
  end

  // assemble the finished item, yaw held at zero on a pole
  logic push;
  assign push          = en && vc[CLAT-1];
  assign res_new.pole  = pole_d[CLAT-1];
  assign res_new.pitch = pitch_a;
  assign res_new.yaw   = pole_d[CLAT-1] ? '0 : yaw_a;
  assign res_new.roll  = roll_a;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_axis_tready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_axis_tready) begin
      if (skid_v) begin
        out_r <= skid;
      end else if (push) begin
        out_r <= res_new;
      end
    end else if (push) begin
      skid <= res_new;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {out_r.roll, out_r.yaw, out_r.pitch};
  assign m_axis_tuser  = out_r.pole;

endmodule
`default_nettype wire
